/* rtl/ppp_pkg.sv */
// ---------------------------------------------------------------------------
// ppp_pkg
// Widths, constants and the divider cell record for the perspective projector.
// ---------------------------------------------------------------------------
package ppp_pkg;

	localparam int COORD_BITS      = 16;
	localparam int MAT_BITS        = 16;
	localparam int MAT_FRAC        = 14;
	localparam int POINT_FRAC      = COORD_BITS - 4;
	localparam int TOTAL_FRAC      = MAT_FRAC + POINT_FRAC;
	localparam int PROD_W          = MAT_BITS + COORD_BITS;
	localparam int ACC_W           = PROD_W + 2;
	localparam int DEN_W           = ACC_W + 1;
	localparam int NUM_W           = ACC_W + 9;
	localparam int MAG_W           = NUM_W - 1;
	localparam int N_W             = MAG_W + 2;
	localparam int QBITS           = 17;
	localparam int DIV_W           = DEN_W + QBITS;
	localparam int OUT_W           = 16;
	localparam int SUM_W           = QBITS + 2;
	localparam int SCR_W           = 13;
	localparam int CFG_W           = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int PROJ_SCALE      = 300;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

	localparam logic [CFG_W-1:0] ROW_X_RST = 64'd16384;
	localparam logic [CFG_W-1:0] ROW_Y_RST = 64'd1073741824;
	localparam logic [CFG_W-1:0] ROW_Z_RST = 64'd70368744177664;
	localparam logic [SCR_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [SCR_W-1:0] HEIGHT_RST = 13'd480;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -16'sh8000;

	typedef struct packed {
		logic             valid;
		logic [DIV_W-1:0] rem_x;
		logic [DIV_W-1:0] rem_y;
		logic [DIV_W-1:0] dsh;
		logic [QBITS-1:0] q_x;
		logic [QBITS-1:0] q_y;
		logic             neg_x;
		logic             neg_y;
		logic             ovf_x;
		logic             ovf_y;
		logic             behind;
	} ppp_cell_t;

endpackage

/* rtl/ppp_ifs.sv */
// ---------------------------------------------------------------------------
// ppp_ifs
// Request channels: input point and projected screen position.
// ---------------------------------------------------------------------------
interface ppp_point_if import ppp_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_screen_if import ppp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] screen_x;
	logic signed [OUT_W-1:0] screen_y;
	logic                    behind_viewer;
	logic                    clipped;
	modport source (output valid, screen_x, screen_y, behind_viewer, clipped, input ready);
	modport sink (input valid, screen_x, screen_y, behind_viewer, clipped, output ready);
endinterface

/* rtl/ppp_transform.sv */
// ---------------------------------------------------------------------------
// ppp_transform
// Affine transform, projection numerators and divider setup (four stages).
// ---------------------------------------------------------------------------
module ppp_transform import ppp_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  logic signed [COORD_BITS-1:0] pz,
	input  logic [CFG_W-1:0]             row_x,
	input  logic [CFG_W-1:0]             row_y,
	input  logic [CFG_W-1:0]             row_z,
	output ppp_cell_t                    head
);
	logic signed [PROD_W-1:0]   prod_s1 [3][3];
	logic signed [MAT_BITS-1:0] trans_s1 [3];
	logic                       valid_s1, valid_s2, valid_s3;
	logic signed [ACC_W-1:0]    acc_s2 [3];
	logic                       neg_x_s3, neg_y_s3, behind_s3;
	logic [MAG_W-1:0]           mag_x_s3, mag_y_s3;
	logic signed [DEN_W-1:0]    den_s3;
	logic signed [COORD_BITS-1:0] pt [3];
	logic [CFG_W-1:0]           rows [3];
	logic signed [ACC_W-1:0]    acc_c [3];
	logic signed [NUM_W-1:0]    num_x, num_y;
	logic signed [DEN_W-1:0]    den_c;
	logic [N_W-1:0]             n_x, n_y;
	logic [DIV_W-1:0]           dsh_c;
	ppp_cell_t                  cell_c;

	assign pt   = '{px, py, pz};
	assign rows = '{row_x, row_y, row_z};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_c[r] = ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1]) + ACC_W'(prod_s1[r][2])
				+ (ACC_W'(trans_s1[r]) <<< POINT_FRAC);
		end
		num_x = NUM_W'(acc_s2[0]) * NUM_W'(PROJ_SCALE);
		num_y = NUM_W'(acc_s2[1]) * NUM_W'(PROJ_SCALE);
		den_c = (DEN_W'(3) <<< TOTAL_FRAC) + DEN_W'(acc_s2[2]);
		n_x   = {mag_x_s3, 1'b0} + N_W'(den_s3);
		n_y   = {mag_y_s3, 1'b0} + N_W'(den_s3);
		dsh_c = DIV_W'({den_s3, 1'b0}) << (QBITS - 1);
		cell_c.valid  = valid_s3;
		cell_c.rem_x  = DIV_W'(n_x);
		cell_c.rem_y  = DIV_W'(n_y);
		cell_c.dsh    = dsh_c;
		cell_c.q_x    = '0;
		cell_c.q_y    = '0;
		cell_c.neg_x  = neg_x_s3;
		cell_c.neg_y  = neg_y_s3;
		cell_c.ovf_x  = DIV_W'(n_x) >= {dsh_c[DIV_W-2:0], 1'b0} || dsh_c[DIV_W-1];
		cell_c.ovf_y  = DIV_W'(n_y) >= {dsh_c[DIV_W-2:0], 1'b0} || dsh_c[DIV_W-1];
		cell_c.behind = behind_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			head.valid <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			head     <= cell_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= $signed(rows[r][MAT_BITS*c +: MAT_BITS]) * pt[c];
				end
				trans_s1[r] <= $signed(rows[r][MAT_BITS*3 +: MAT_BITS]);
				acc_s2[r]   <= acc_c[r];
			end
			neg_x_s3  <= num_x < 0;
			neg_y_s3  <= num_y < 0;
			mag_x_s3  <= (num_x < 0) ? MAG_W'(-num_x) : MAG_W'(num_x);
			mag_y_s3  <= (num_y < 0) ? MAG_W'(-num_y) : MAG_W'(num_y);
			den_s3    <= den_c;
			behind_s3 <= den_c <= 0;
		end
	end

endmodule

/* rtl/ppp_div_cell.sv */
// ---------------------------------------------------------------------------
// ppp_div_cell
// One restoring-division step for both screen axes, registered.
// ---------------------------------------------------------------------------
module ppp_div_cell import ppp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  ppp_cell_t cin,
	output ppp_cell_t cout
);
	logic      ge_x, ge_y;
	ppp_cell_t nxt;

	always_comb begin
		ge_x      = cin.rem_x >= cin.dsh;
		ge_y      = cin.rem_y >= cin.dsh;
		nxt       = cin;
		nxt.rem_x = ge_x ? cin.rem_x - cin.dsh : cin.rem_x;
		nxt.rem_y = ge_y ? cin.rem_y - cin.dsh : cin.rem_y;
		nxt.q_x   = {cin.q_x[QBITS-2:0], ge_x};
		nxt.q_y   = {cin.q_y[QBITS-2:0], ge_y};
		nxt.dsh   = cin.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout.valid <= 1'b0;
		end else if (en) begin
			cout <= nxt;
		end
	end

endmodule

/* rtl/perspective_point_projection.sv */
// ---------------------------------------------------------------------------
// perspective_point_projection
// Affine transform and perspective projection of 3D points to screen pixels.
//
//  channel  dir  contents
//  point    in   point_x, point_y, point_z (Q4.12)
//  screen   out  screen_x, screen_y, behind_viewer, clipped
//  cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One point per cycle unless the output stalls. Pipeline: 4 transform stages,
// 17 divider cells, output register; the divider cell chain is most of it.
// Reset clears only valid bits and loads the configuration defaults.
// A stalled output freezes the whole pipeline; point.ready follows it.
// ---------------------------------------------------------------------------
module perspective_point_projection import ppp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	ppp_point_if.sink            point,
	ppp_screen_if.source         screen,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	logic [CFG_W-1:0]        row_x_q, row_y_q, row_z_q;
	logic [SCR_W-1:0]        width_q, height_q;
	logic                    en;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] sx_q, sy_q;
	logic                    behind_q, clip_q;
	ppp_cell_t               chain [QBITS+1];
	ppp_cell_t               last;
	logic signed [SUM_W-1:0] qx, qy, sum_x, sum_y;
	logic signed [OUT_W-1:0] sx_c, sy_c;
	logic                    clip_x, clip_y;

	assign en          = !out_valid_q || screen.ready;
	assign point.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= ROW_X_RST;
			row_y_q  <= ROW_Y_RST;
			row_z_q  <= ROW_Z_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_X:  row_x_q  <= cfg_data;
				REG_ROW_Y:  row_y_q  <= cfg_data;
				REG_ROW_Z:  row_z_q  <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[SCR_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	ppp_transform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (point.valid),
		.px       (point.point_x),
		.py       (point.point_y),
		.pz       (point.point_z),
		.row_x    (row_x_q),
		.row_y    (row_y_q),
		.row_z    (row_z_q),
		.head     (chain[0])
	);

	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		ppp_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cin    (chain[i]),
			.cout   (chain[i+1])
		);
	end

	assign last = chain[QBITS];

	always_comb begin
		qx     = SUM_W'(last.q_x);
		qy     = SUM_W'(last.q_y);
		sum_x  = SUM_W'(width_q[SCR_W-1:1]) + (last.neg_x ? -qx : qx);
		sum_y  = SUM_W'(height_q[SCR_W-1:1]) - (last.neg_y ? -qy : qy);
		clip_x = 1'b1;
		clip_y = 1'b1;
		priority if (last.ovf_x) begin
			sx_c = last.neg_x ? OUT_MIN : OUT_MAX;
		end else if (sum_x > SUM_W'(OUT_MAX)) begin
			sx_c = OUT_MAX;
		end else if (sum_x < SUM_W'(OUT_MIN)) begin
			sx_c = OUT_MIN;
		end else begin
			sx_c   = OUT_W'(sum_x);
			clip_x = 1'b0;
		end
		priority if (last.ovf_y) begin
			sy_c = last.neg_y ? OUT_MAX : OUT_MIN;
		end else if (sum_y > SUM_W'(OUT_MAX)) begin
			sy_c = OUT_MAX;
		end else if (sum_y < SUM_W'(OUT_MIN)) begin
			sy_c = OUT_MIN;
		end else begin
			sy_c   = OUT_W'(sum_y);
			clip_y = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_q     <= last.behind ? '0 : sx_c;
			sy_q     <= last.behind ? '0 : sy_c;
			behind_q <= last.behind;
			clip_q   <= !last.behind && (clip_x || clip_y);
		end
	end

	assign screen.valid         = out_valid_q;
	assign screen.screen_x      = sx_q;
	assign screen.screen_y      = sy_q;
	assign screen.behind_viewer = behind_q;
	assign screen.clipped       = clip_q;

`ifndef NO_ASSERTIONS
	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		screen.valid && screen.behind_viewer |->
			screen.screen_x == 0 && screen.screen_y == 0 && !screen.clipped)
		else $error("behind point with nonzero output");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		screen.valid && screen.clipped |->
			screen.screen_x == OUT_MAX || screen.screen_x == OUT_MIN ||
			screen.screen_y == OUT_MAX || screen.screen_y == OUT_MIN)
		else $error("clipped without saturated coordinate");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(last) && $stable(chain[0]))
		else $error("pipeline moved during stall");
`endif

endmodule
